@@ rtl/drctc_pkg.sv @@
// ----------------------------------------------------------------------------
// drctc_pkg
// shared types and constants for the dual-rail cube table check
// ----------------------------------------------------------------------------
package drctc_pkg;

  localparam int VEC_BITS    = 16;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [VEC_BITS-1:0] vec_t;

  typedef struct packed {
    logic [1:0] req_type;
    vec_t       cube_word;
    vec_t       present_vector;
    vec_t       care_mask;
  } in_word_t;

  typedef struct packed {
    logic cube_covered;
    vec_t implied_vector;
    logic any_applied;
    logic status;
  } out_word_t;

endpackage

@@ rtl/dual_rail_cube_table_check_top.sv @@
// ----------------------------------------------------------------------------
// dual_rail_cube_table_check_top
// table of dual-rail cubes with clear, append and a sequential query walk
// ----------------------------------------------------------------------------
//
//  channel   ports                    handshake
//  --------  -----------------------  ----------------------------------------
//  request   in_word                  taken at a clock edge with start && !busy
//  result    result                   valid for one cycle while done is high
//
//  clear, append and an unknown request code give their result word in the
//  cycle after they are taken; busy stays low, so a new word may follow at once
//  a query walks the stored cubes one per cycle through a single compare and
//  and-accumulate unit; busy stays high for the walk and the result word is
//  registered with the last cube; a query on an empty table answers like an update
//  reset (rst, synchronous) empties the table; no clearing pass is needed
//  the receiver cannot stall: each result word is shown for one cycle only
//
module dual_rail_cube_table_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  drctc_pkg::in_word_t in_word,
  output logic                done,
  output drctc_pkg::out_word_t result
);
  import drctc_pkg::*;

  // sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;

  // cube store, registered read port
  vec_t             store [TABLE_DEPTH];
  vec_t             rd_data;
  logic [IDX_W-1:0] rd_addr;

  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   idx;

  // query operands held for the whole walk
  vec_t present;
  vec_t mask;
  logic mask_all;

  // running query results
  logic covered;
  logic applied;
  vec_t acc;

  // shared compare and accumulate unit
  logic is_subset;
  logic applies;
  logic covered_next;
  logic applied_next;
  vec_t acc_next;
  logic last;

  logic accept;
  logic table_full;

  // word loaded at accept: all zero, only a dropped append flags status
  out_word_t upd_result;

  assign accept     = start && !busy;
  assign busy       = (state == ST_SCAN);
  assign table_full = (count == COUNT_W'(TABLE_DEPTH));

  always_comb begin
    upd_result = '0;
    if ((in_word.req_type == REQ_APPEND) && table_full) begin
      upd_result.status = STATUS_FULL;
    end
  end

  // the entry at index 0 is fetched while idle, the next one while scanning
  assign rd_addr = (state == ST_IDLE) ? '0 : IDX_W'(idx + 1'b1);

  assign is_subset    = ((rd_data & ~present) == '0);
  assign applies      = mask_all || ((~mask & ~present & rd_data) == '0);
  assign covered_next = covered || is_subset;
  assign applied_next = applied || applies;
  assign acc_next     = applies ? (acc & rd_data) : acc;
  assign last         = ((COUNT_W'(idx) + 1'b1) == count);

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
    if (accept && (in_word.req_type == REQ_APPEND) && !table_full) begin
      store[count[IDX_W-1:0]] <= in_word.cube_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            result <= upd_result;
            unique case (in_word.req_type)
              REQ_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              REQ_APPEND: begin
                if (!table_full) begin
                  count <= count + 1'b1;
                end
                done <= 1'b1;
              end
              REQ_QUERY: begin
                if (count == '0) begin
                  // empty table: all fields zero
                  done <= 1'b1;
                end else begin
                  present  <= in_word.present_vector;
                  mask     <= in_word.care_mask;
                  mask_all <= &in_word.care_mask;
                  acc      <= in_word.care_mask;
                  covered  <= 1'b0;
                  applied  <= 1'b0;
                  idx      <= '0;
                  state    <= ST_SCAN;
                end
              end
              default: begin
                // unused code: no change, zero result
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          covered <= covered_next;
          applied <= applied_next;
          acc     <= acc_next;
          idx     <= idx + 1'b1;
          if (last) begin
            result.cube_covered   <= covered_next;
            result.implied_vector <= applied_next ? acc_next : '0;
            result.any_applied    <= applied_next;
            result.status         <= STATUS_OK;
            done                  <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/drctc_checker.sv @@
// ----------------------------------------------------------------------------
// drctc_checker
// port-level checks on the cube table check, attached by bind
// ----------------------------------------------------------------------------
module drctc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input drctc_pkg::in_word_t  in_word,
  input logic                 done,
  input drctc_pkg::out_word_t result
);
  import drctc_pkg::*;

  // a dropped append carries no query answers
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    done && result.status |->
      !result.cube_covered && (result.implied_vector == '0) && !result.any_applied)
    else $error("full status with query fields set");

  // nothing applied means nothing implied
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.any_applied |-> (result.implied_vector == '0))
    else $error("implied vector set with no applying cube");

  // non-query words answer in the next cycle
  a_update_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (in_word.req_type != REQ_QUERY) |=> done && !busy)
    else $error("missing result after non-query word");

  // end of a walk always delivers its result
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("query walk ended without a result");

endmodule

bind dual_rail_cube_table_check_top drctc_checker u_drctc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .in_word (in_word),
  .done    (done),
  .result  (result)
);

@@ tb/tb_dual_rail_cube_table_check_top.sv @@
// ----------------------------------------------------------------------------
// tb_dual_rail_cube_table_check_top
// self-checking bench for the dual-rail cube table: clear, append and query
// words go in through the start/busy handshake, and a shadow copy of the cube
// table predicts every result word, which is compared field by field
// ----------------------------------------------------------------------------
module tb_dual_rail_cube_table_check_top;

  import drctc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 10;
  localparam int WORD_TARGET = 1200;
  // worst case is a full-table walk plus an idle gap for every word;
  // the limit allows a wide margin over the whole run
  localparam int CYCLE_LIMIT = 200000;
  // a query may still be walking the table after the last expected word
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 4;
  localparam int HALF_BITS    = VEC_BITS / 2;

  // request code with no meaning; the block must leave the table alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // shadow of the cube table; predicts and checks result words
  class cube_table_checker;
    vec_t      shadow_cubes[TABLE_DEPTH];
    int        shadow_count;
    out_word_t pending_results[$];
    int        mismatch_count;

    function new();
      shadow_count   = 0;
      mismatch_count = 0;
    endfunction

    // updates the shadow table and returns the word the block should give
    function out_word_t apply_request(in_word_t w);
      out_word_t r;
      vec_t      acc;
      r = '0;
      case (w.req_type)
        REQ_CLEAR: shadow_count = 0;
        REQ_APPEND: begin
          if (shadow_count < TABLE_DEPTH) begin
            shadow_cubes[shadow_count] = w.cube_word;
            shadow_count++;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        REQ_QUERY: begin
          acc = w.care_mask;
          for (int i = 0; i < shadow_count; i++) begin
            if ((shadow_cubes[i] & ~w.present_vector) == '0)
              r.cube_covered = 1'b1;
            if ((&w.care_mask) ||
                ((~w.care_mask & ~w.present_vector & shadow_cubes[i]) == '0)) begin
              acc &= shadow_cubes[i];
              r.any_applied = 1'b1;
            end
          end
          if (r.any_applied)
            r.implied_vector = acc;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(in_word_t w);
      pending_results.push_back(apply_request(w));
    endfunction

    function void compare_field(string name, logic [VEC_BITS-1:0] want,
                                logic [VEC_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        $error("result word arrived with none expected");
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("cube_covered", vec_t'(want.cube_covered), vec_t'(got.cube_covered));
      compare_field("implied_vector", want.implied_vector, got.implied_vector);
      compare_field("any_applied", vec_t'(want.any_applied), vec_t'(got.any_applied));
      compare_field("status", vec_t'(want.status), vec_t'(got.status));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      done;
  out_word_t result;

  cube_table_checker checker_h;
  int        words_sent;
  int        burst_left;
  int        cycle_count;
  vec_t      recent_cubes[$];   // cubes appended since the last clear, for query hints

  dual_rail_cube_table_check_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // monitor: a result shown this cycle belongs to an older word, so check
  // before noting a word taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        checker_h.check_result(result);
      if (start && !busy)
        checker_h.note_request(in_word);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic in_word_t make_word(logic [1:0] req, vec_t cube, vec_t present,
                                         vec_t mask);
    in_word_t w;
    w.req_type       = req;
    w.cube_word      = cube;
    w.present_vector = present;
    w.care_mask      = mask;
    return w;
  endfunction

  // any request code, unused code included, with fully random fields
  function automatic in_word_t noise_word();
    return make_word(2'($urandom_range(0, 3)), vec_t'($urandom), vec_t'($urandom),
                     vec_t'($urandom));
  endfunction

  // mostly well-formed dual-rail cubes: each position is one, zero or free
  function automatic vec_t rand_cube();
    vec_t c;
    int   free_odds;
    c = '0;
    if ($urandom_range(0, 7) == 0)
      return vec_t'($urandom);
    free_odds = $urandom_range(1, 6);
    for (int p = 0; p < HALF_BITS; p++) begin
      if ($urandom_range(0, free_odds) < 2) begin
        if ($urandom_range(0, 1) == 1)
          c[p] = 1'b1;
        else
          c[p + HALF_BITS] = 1'b1;
      end
    end
    return c;
  endfunction

  // present vector: often a superset of a stored cube so forward hits occur
  function automatic vec_t rand_present();
    vec_t hint;
    hint = (recent_cubes.size() > 0) ?
           recent_cubes[$urandom_range(0, recent_cubes.size() - 1)] : rand_cube();
    case ($urandom_range(0, 3))
      0:       return vec_t'($urandom);
      1:       return rand_cube();
      default: return hint | rand_cube();
    endcase
  endfunction

  // care mask: all ones, zero, random, or close to the inverse of present so
  // that some cubes apply and some do not
  function automatic vec_t rand_mask(vec_t present);
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2:       return vec_t'($urandom);
      3:       return ~present;
      default: return ~present ^ (vec_t'($urandom) & vec_t'($urandom) & vec_t'($urandom));
    endcase
  endfunction

  function automatic in_word_t query_word();
    vec_t p;
    p = rand_present();
    return make_word(REQ_QUERY, vec_t'($urandom), p, rand_mask(p));
  endfunction

  // hold start low for the requested idle time with junk on the word lines
  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= noise_word();
    end
  endtask

  // present one word and wait until the block takes it
  task automatic send_word(in_word_t w);
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // sender runs in bursts; a fresh burst starts after a random gap, and some
  // bursts are long stretches with no idling at all
  task automatic issue(in_word_t w);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                                                 $urandom_range(1, 12);
      idle_for($urandom_range(0, 7));
    end
    burst_left--;
    if (w.req_type == REQ_CLEAR)
      recent_cubes.delete();
    else if (w.req_type == REQ_APPEND)
      recent_cubes.push_back(w.cube_word);
    send_word(w);
  endtask

  task automatic issue_append(vec_t cube);
    issue(make_word(REQ_APPEND, cube, vec_t'($urandom), vec_t'($urandom)));
  endtask

  initial begin
    int n_app;
    int n_q;

    checker_h   = new();
    words_sent  = 0;
    burst_left  = 0;
    cycle_count = 0;
    rst     = 1'b1;
    start   = 1'b0;
    in_word = '0;
    repeat (RESET_LEN) @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, unused code, extreme cubes, then fill past full
    issue(make_word(REQ_QUERY, '0, '0, '0));
    issue(make_word(REQ_UNUSED, '1, '1, '1));
    issue_append('0);                          // empty cube covers everything
    issue_append('1);                          // contradictory cube, covered only by an all-ones present vector
    issue(make_word(REQ_QUERY, '1, '0, '0));
    issue(make_word(REQ_QUERY, '0, '1, '1));   // all-ones mask, every cube applies
    repeat (TABLE_DEPTH - 2) issue_append(rand_cube());
    issue_append('1);                          // table full, dropped
    issue(make_word(REQ_QUERY, '0, vec_t'($urandom), '1));
    issue(make_word(REQ_CLEAR, '1, '1, '1));
    issue(make_word(REQ_QUERY, '0, '1, '0));   // empty again after clear

    // random sessions: clear, fill, query; with some noise and no-clear runs
    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        issue(noise_word());
      end else begin
        if ($urandom_range(0, 4) != 0)
          issue(make_word(REQ_CLEAR, vec_t'($urandom), vec_t'($urandom),
                          vec_t'($urandom)));
        n_app = ($urandom_range(0, 5) == 0) ? $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4)
                                            : $urandom_range(0, 6);
        repeat (n_app) issue_append(rand_cube());
        n_q = $urandom_range(1, 6);
        repeat (n_q) issue(query_word());
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // wait for every expected word, then a little longer for strays
    while (checker_h.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (checker_h.mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
